>>> src/dwhs_pkg.sv
// Shared request and status codes for the half-swap deque.
package dwhs_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned REQ_W  = 3;
	localparam int unsigned STAT_W = 2;

	localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_SWAP_HALF  = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

endpackage

>>> src/dwhs_ram.sv
// Ring store: one write port, one read port, registered read data.
module dwhs_ram #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = 10
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [AW-1:0]                        waddr,
	input  logic signed [dwhs_pkg::DATA_W-1:0]   wdata,
	input  logic                                 re,
	input  logic [AW-1:0]                        raddr,
	output logic signed [dwhs_pkg::DATA_W-1:0]   rdata
);

	logic signed [dwhs_pkg::DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/deque_with_half_swap_core.sv
// Top level of the double-ended queue with half swap.
// Usage:
//  A request (req_type, data_in) is taken on a rising edge where start is
//  high and busy is low. Codes: push front, push back, pop front, pop back,
//  swap halves (the middle word becomes the front); other codes do nothing.
//  Each request gives one result word: data_out, status, size, middle_pos,
//  shown for a single cycle with done high. The receiver cannot stall.
//  Pushes, swaps, failed pops and unused codes give done in the cycle
//  after acceptance, so one request per cycle is taken while busy is low.
//  A successful pop reads the ring memory, whose read data is registered:
//  busy is high for one cycle while the word lands in the read register,
//  then done comes with the word in the result register; none is taken meanwhile.
//  Pushing onto a full queue is ignored and flagged; popping an empty one
//  returns zero and is flagged.
//  Reset (arst_n low) empties the queue and clears the pointers at once;
//  memory contents are not cleared and no clearing pass is needed.
module deque_with_half_swap_core #(
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW = $clog2(DEPTH),
	localparam int unsigned CW = $clog2(DEPTH + 1),
	localparam int unsigned MW = $clog2(DEPTH / 2 + 2)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [dwhs_pkg::REQ_W-1:0]           req_type,
	input  logic signed [dwhs_pkg::DATA_W-1:0]   data_in,
	output logic                                 done,
	output logic signed [dwhs_pkg::DATA_W-1:0]   data_out,
	output logic [dwhs_pkg::STAT_W-1:0]          status,
	output logic [CW-1:0]                        size,
	output logic [MW-1:0]                        middle_pos
);

	localparam int unsigned SW = AW + 1;

	logic [AW-1:0] front_q;
	logic [CW-1:0] count_q;
	logic          busy_q;
	logic          done_q;
	logic signed [dwhs_pkg::DATA_W-1:0] data_out_q;
	logic [dwhs_pkg::STAT_W-1:0] status_q;
	logic [CW-1:0] size_q;
	logic [MW-1:0] mid_q;

	logic          accept;
	logic          full;
	logic          empty;
	logic [AW-1:0] front_dec;
	logic [AW-1:0] front_inc;
	logic [AW-1:0] back_slot;
	logic [AW-1:0] last_slot;
	logic [AW-1:0] swap_slot;

	logic [AW-1:0] front_nx;
	logic [CW-1:0] count_nx;
	logic [dwhs_pkg::STAT_W-1:0] status_nx;
	logic          we;
	logic [AW-1:0] waddr;
	logic          re;
	logic [AW-1:0] raddr;
	logic signed [dwhs_pkg::DATA_W-1:0] rdata;

	// front plus an offset below DEPTH, wrapped into the ring
	function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
			input logic [AW-1:0] off);
		logic [SW-1:0] sum;
		sum = SW'(base) + SW'(off);
		if (sum >= SW'(DEPTH)) begin
			sum = sum - SW'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	assign accept = start && !busy_q;
	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);

	assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
	assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);
	assign back_slot = ring_add(front_q, AW'(count_q));
	assign last_slot = ring_add(front_q, AW'(count_q - CW'(1)));
	assign swap_slot = ring_add(front_q, AW'(count_q >> 1));

	always_comb begin
		front_nx  = front_q;
		count_nx  = count_q;
		status_nx = dwhs_pkg::STAT_OK;
		we        = 1'b0;
		waddr     = back_slot;
		re        = 1'b0;
		raddr     = front_q;
		unique case (req_type)
			dwhs_pkg::REQ_PUSH_FRONT: begin
				if (full) begin
					status_nx = dwhs_pkg::STAT_FULL;
				end else begin
					front_nx = front_dec;
					count_nx = count_q + CW'(1);
					we       = accept;
					waddr    = front_dec;
				end
			end
			dwhs_pkg::REQ_PUSH_BACK: begin
				if (full) begin
					status_nx = dwhs_pkg::STAT_FULL;
				end else begin
					count_nx = count_q + CW'(1);
					we       = accept;
				end
			end
			dwhs_pkg::REQ_POP_FRONT: begin
				if (empty) begin
					status_nx = dwhs_pkg::STAT_EMPTY;
				end else begin
					front_nx = front_inc;
					count_nx = count_q - CW'(1);
					re       = accept;
				end
			end
			dwhs_pkg::REQ_POP_BACK: begin
				if (empty) begin
					status_nx = dwhs_pkg::STAT_EMPTY;
				end else begin
					count_nx = count_q - CW'(1);
					re       = accept;
					raddr    = last_slot;
				end
			end
			dwhs_pkg::REQ_SWAP_HALF: begin
				front_nx = swap_slot;
			end
			default: begin
			end
		endcase
	end

	dwhs_ram #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(data_in),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				// read word has landed: release the popped word
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else if (accept) begin
				front_q <= front_nx;
				count_q <= count_nx;
				busy_q  <= re;
				done_q  <= !re;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			data_out_q <= rdata;
		end else if (accept) begin
			data_out_q <= '0;
			status_q   <= status_nx;
			size_q     <= count_nx;
			mid_q      <= (count_nx == '0) ? '0 : MW'(count_nx >> 1) + MW'(1);
		end
	end

	assign busy       = busy_q;
	assign done       = done_q;
	assign data_out   = data_out_q;
	assign status     = status_q;
	assign size       = size_q;
	assign middle_pos = mid_q;

endmodule
